FILE: sv/aisu_pkg.sv
// Types, constants and saturation helpers for the active Ising stencil update unit.
// Used by every module of the block; depends on nothing.
package aisu_pkg;

  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 20;
  localparam int ARG_W   = 24;
  localparam int EXP_W   = 33;
  localparam int EINV_W  = 21;
  localparam int HPOLY_W = 22;
  localparam int SAT_W   = 48;
  localparam int HORNER_N = 7;

  localparam logic [ARG_W-1:0]   ARG_LIMIT = 24'h800000;
  localparam logic [20:0]        LOG2E_Q   = 21'd1512775;
  localparam logic [19:0]        LN2_Q     = 20'd726817;
  localparam logic [HPOLY_W-1:0] QONE      = 22'h100000;

  localparam logic signed [SAT_W-1:0] SAT_MAX = 48'sd2147483647;
  localparam logic signed [SAT_W-1:0] SAT_MIN = -48'sd2147483648;

  typedef enum logic [1:0] {
    REG_ADVECT,
    REG_DIFFUSE,
    REG_GAIN,
    REG_BETA
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] rc;
    logic signed [DATA_W-1:0] mc;
    logic signed [DATA_W-1:0] grad_m;
    logic signed [DATA_W-1:0] grad_r;
    logic signed [DATA_W-1:0] lap_r;
    logic signed [DATA_W-1:0] lap_m;
    logic [EXP_W-1:0]         e_val;
    logic                     invalid;
    logic                     ovf;
    logic                     neg;
    logic                     quot_ovf;
  } side_t;

  function automatic logic sat_hit(input logic signed [SAT_W-1:0] x);
    return (x > SAT_MAX) || (x < SAT_MIN);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SAT_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (x < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/aisu_div_pipe.sv
// Pipelined restoring divider, STEP_BITS quotient bits per stage, with sideband.
// Depends on aisu_pkg (side_t).
module aisu_div_pipe #(
  parameter int DEN_W     = 31,
  parameter int REM_W     = 63,
  parameter int Q_W       = 24,
  parameter int STEP_BITS = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [REM_W-1:0]     rem_i,
  input  logic [DEN_W-1:0]     den_i,
  input  aisu_pkg::side_t      side_i,
  output logic                 valid_o,
  output logic [Q_W-1:0]       quot_o,
  output aisu_pkg::side_t      side_o
);

  localparam int NSTG = (Q_W + STEP_BITS - 1) / STEP_BITS;

  logic                 valid_q [NSTG];
  logic [REM_W-1:0]     rem_q   [NSTG];
  logic [DEN_W-1:0]     den_q   [NSTG];
  logic [Q_W-1:0]       quot_q  [NSTG];
  aisu_pkg::side_t      side_q  [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    logic            v_in;
    logic [REM_W-1:0] rem_in, rem_d;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quot_in, quot_d;
    aisu_pkg::side_t  side_in;

    if (g == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = rem_i;
      assign den_in  = den_i;
      assign quot_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign den_in  = den_q[g-1];
      assign quot_in = quot_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_comb begin
      logic [REM_W-1:0] trial;
      rem_d  = rem_in;
      quot_d = quot_in;
      trial  = '0;
      for (int j = 0; j < STEP_BITS; j++) begin
        if (Q_W - 1 - g * STEP_BITS - j >= 0) begin
          trial = REM_W'(den_in) << (Q_W - 1 - g * STEP_BITS - j);
          if (rem_d >= trial) begin
            rem_d = rem_d - trial;
            quot_d[Q_W - 1 - g * STEP_BITS - j] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i && v_in) begin
        rem_q[g]  <= rem_d;
        den_q[g]  <= den_in;
        quot_q[g] <= quot_d;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NSTG-1];
  assign quot_o  = quot_q[NSTG-1];
  assign side_o  = side_q[NSTG-1];

endmodule

FILE: sv/aisu_exp_pipe.sv
// Pipelined e^a for 0 <= a <= 8: base-2 split, degree-7 Horner series, shift by k.
// Depends on aisu_pkg; result goes out in side_o.e_val.
module aisu_exp_pipe (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [aisu_pkg::ARG_W-1:0]   arg_i,
  input  aisu_pkg::side_t              side_i,
  output logic                         valid_o,
  output aisu_pkg::side_t              side_o
);

  localparam int HN = aisu_pkg::HORNER_N;
  localparam int PW = aisu_pkg::HPOLY_W;

  logic            t_v_q, r_v_q, e_v_q;
  logic [23:0]     t_q;
  logic [19:0]     r_q;
  logic [3:0]      k_q;
  aisu_pkg::side_t t_side_q, r_side_q, e_side_q;
  logic [aisu_pkg::EXP_W-1:0] e_q;

  // per Horner step: A holds the product, B the updated polynomial
  logic            a_v_q    [HN];
  logic [20:0]     a_x_q    [HN];
  logic [19:0]     a_r_q    [HN];
  logic [3:0]      a_k_q    [HN];
  aisu_pkg::side_t a_side_q [HN];
  logic            b_v_q    [HN];
  logic [PW-1:0]   b_p_q    [HN];
  logic [19:0]     b_r_q    [HN];
  logic [3:0]      b_k_q    [HN];
  aisu_pkg::side_t b_side_q [HN];

  logic [23:0] t_d;
  logic [19:0] r_d;
  logic [aisu_pkg::EXP_W-1:0] e_d;

  assign t_d = 24'((45'(arg_i) * 45'(aisu_pkg::LOG2E_Q)) >> aisu_pkg::FRAC_W);
  assign r_d = 20'((40'(t_q[19:0]) * 40'(aisu_pkg::LN2_Q)) >> aisu_pkg::FRAC_W);
  assign e_d = aisu_pkg::EXP_W'(b_p_q[HN-1]) << b_k_q[HN-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_v_q <= 1'b0;
      r_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else if (en_i) begin
      t_v_q <= valid_i;
      r_v_q <= t_v_q;
      e_v_q <= b_v_q[HN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (valid_i) begin
        t_q      <= t_d;
        t_side_q <= side_i;
      end
      if (t_v_q) begin
        r_q      <= r_d;
        k_q      <= t_q[23:20];
        r_side_q <= t_side_q;
      end
      if (b_v_q[HN-1]) begin
        e_q      <= e_d;
        e_side_q <= b_side_q[HN-1];
      end
    end
  end

  for (genvar g = 0; g < HN; g++) begin : g_horner
    localparam int DIVR = HN - g;
    localparam logic [24:0] RECIP = 25'((64'd1 << 24) / DIVR);

    logic            v_in;
    logic [PW-1:0]   p_in;
    logic [19:0]     r_in;
    logic [3:0]      k_in;
    aisu_pkg::side_t side_in;
    logic [20:0]     x_d;
    logic [PW-1:0]   q0, rm, p_d;

    if (g == 0) begin : g_first
      assign v_in    = r_v_q;
      assign p_in    = aisu_pkg::QONE;
      assign r_in    = r_q;
      assign k_in    = k_q;
      assign side_in = r_side_q;
    end else begin : g_next
      assign v_in    = b_v_q[g-1];
      assign p_in    = b_p_q[g-1];
      assign r_in    = b_r_q[g-1];
      assign k_in    = b_k_q[g-1];
      assign side_in = b_side_q[g-1];
    end

    assign x_d = 21'((42'(p_in) * 42'(r_in)) >> aisu_pkg::FRAC_W);
    // floor(x / DIVR): reciprocal estimate is low by at most one
    assign q0  = PW'((46'(a_x_q[g]) * 46'(RECIP)) >> 24);
    assign rm  = PW'(a_x_q[g]) - PW'(q0 * PW'(DIVR));
    assign p_d = aisu_pkg::QONE + q0 + PW'(rm >= PW'(DIVR));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_v_q[g] <= 1'b0;
        b_v_q[g] <= 1'b0;
      end else if (en_i) begin
        a_v_q[g] <= v_in;
        b_v_q[g] <= a_v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_in) begin
          a_x_q[g]    <= x_d;
          a_r_q[g]    <= r_in;
          a_k_q[g]    <= k_in;
          a_side_q[g] <= side_in;
        end
        if (a_v_q[g]) begin
          b_p_q[g]    <= p_d;
          b_r_q[g]    <= a_r_q[g];
          b_k_q[g]    <= a_k_q[g];
          b_side_q[g] <= a_side_q[g];
        end
      end
    end
  end

  always_comb begin
    side_o       = e_side_q;
    side_o.e_val = e_q;
  end

  assign valid_o = e_v_q;

endmodule

FILE: sv/active_ising_stencil_update_unit.sv
// Active Ising stencil update: one FTCS step of density and magnetization per site.
// 48 register stages from request to result; one request per cycle while the output is not stalled.
// The whole pipeline advances together and holds while the result register is not taken.
// Reset clears all valid bits and the four coefficient registers to zero.
// Depends on aisu_pkg, aisu_div_pipe and aisu_exp_pipe.
module active_ising_stencil_update_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic signed [31:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] rho_left_i,
  input  logic signed [31:0] rho_mid_i,
  input  logic signed [31:0] rho_right_i,
  input  logic signed [31:0] mag_left_i,
  input  logic signed [31:0] mag_mid_i,
  input  logic signed [31:0] mag_right_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] rho_next_o,
  output logic signed [31:0] mag_next_o,
  output logic               density_invalid_o,
  output logic               overflowed_o
);

  localparam int SW = aisu_pkg::SAT_W;
  localparam int FW = aisu_pkg::FRAC_W;

  logic signed [31:0] advect_q, diffuse_q, gain_q, beta_q;
  logic en;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      advect_q  <= '0;
      diffuse_q <= '0;
      gain_q    <= '0;
      beta_q    <= '0;
    end else if (cfg_valid_i) begin
      case (aisu_pkg::cfg_reg_e'(cfg_index_i))
        aisu_pkg::REG_ADVECT:  advect_q  <= cfg_data_i;
        aisu_pkg::REG_DIFFUSE: diffuse_q <= cfg_data_i;
        aisu_pkg::REG_GAIN:    gain_q    <= cfg_data_i;
        aisu_pkg::REG_BETA:    beta_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // s1: gradients, Laplacians, beta*m
  aisu_pkg::side_t    s1_side_d, s1_side_q;
  logic signed [63:0] s1_prod_d, s1_prod_q;
  logic               s1_v_q;
  logic signed [SW-1:0] gm_w, gr_w, lr_w, lm_w;

  always_comb begin
    gm_w = SW'(mag_right_i) - SW'(mag_left_i);
    gr_w = SW'(rho_right_i) - SW'(rho_left_i);
    lr_w = SW'(rho_left_i) + SW'(rho_right_i) - (SW'(rho_mid_i) <<< 1);
    lm_w = SW'(mag_left_i) + SW'(mag_right_i) - (SW'(mag_mid_i) <<< 1);
    s1_side_d          = '0;
    s1_side_d.rc       = rho_mid_i;
    s1_side_d.mc       = mag_mid_i;
    s1_side_d.grad_m   = aisu_pkg::sat_data(gm_w);
    s1_side_d.grad_r   = aisu_pkg::sat_data(gr_w);
    s1_side_d.lap_r    = aisu_pkg::sat_data(lr_w);
    s1_side_d.lap_m    = aisu_pkg::sat_data(lm_w);
    s1_side_d.invalid  = rho_mid_i[31] || (rho_mid_i == '0);
    s1_side_d.ovf      = aisu_pkg::sat_hit(gm_w) || aisu_pkg::sat_hit(gr_w)
                      || aisu_pkg::sat_hit(lr_w) || aisu_pkg::sat_hit(lm_w);
    s1_prod_d = 64'(beta_q) * 64'(mag_mid_i);
  end

  // s2: magnitude of beta*m and quotient range check
  aisu_pkg::side_t s2_side_d, s2_side_q;
  logic [62:0]     s2_mag_d, s2_mag_q;
  logic            s2_v_q;

  always_comb begin
    s2_mag_d = s1_prod_q[63] ? 63'(-s1_prod_q) : s1_prod_q[62:0];
    s2_side_d          = s1_side_q;
    s2_side_d.neg      = s1_prod_q[63];
    s2_side_d.quot_ovf = s2_mag_d[62:24] >= 39'(s1_side_q.rc[30:0]);
  end

  logic                          d1_v;
  logic [aisu_pkg::ARG_W-1:0]    d1_quot;
  aisu_pkg::side_t               d1_side;

  aisu_div_pipe #(
    .DEN_W(31), .REM_W(63), .Q_W(aisu_pkg::ARG_W), .STEP_BITS(2)
  ) u_arg_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s2_v_q), .rem_i(s2_mag_q), .den_i(s2_side_q.rc[30:0]), .side_i(s2_side_q),
    .valid_o(d1_v), .quot_o(d1_quot), .side_o(d1_side)
  );

  // s3: clamp argument to 8
  aisu_pkg::side_t            s3_side_d, s3_side_q;
  logic [aisu_pkg::ARG_W-1:0] s3_arg_d, s3_arg_q;
  logic                       s3_v_q, clamp_w;

  always_comb begin
    clamp_w   = d1_side.quot_ovf || (d1_quot > aisu_pkg::ARG_LIMIT);
    s3_arg_d  = clamp_w ? aisu_pkg::ARG_LIMIT : d1_quot;
    s3_side_d = d1_side;
    s3_side_d.ovf = d1_side.ovf || (clamp_w && !d1_side.invalid);
  end

  logic            ex_v;
  aisu_pkg::side_t ex_side;

  aisu_exp_pipe u_exp (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s3_v_q), .arg_i(s3_arg_q), .side_i(s3_side_q),
    .valid_o(ex_v), .side_o(ex_side)
  );

  logic                        d2_v;
  logic [aisu_pkg::EINV_W-1:0] d2_einv;
  aisu_pkg::side_t             d2_side;

  aisu_div_pipe #(
    .DEN_W(aisu_pkg::EXP_W), .REM_W(54), .Q_W(aisu_pkg::EINV_W), .STEP_BITS(2)
  ) u_inv_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(ex_v), .rem_i(54'(1) << (2 * FW)), .den_i(ex_side.e_val), .side_i(ex_side),
    .valid_o(d2_v), .quot_o(d2_einv), .side_o(d2_side)
  );

  // s4: cosh and sinh
  logic [32:0]        s4_ch_d, s4_ch_q;
  logic signed [33:0] s4_sh_d, s4_sh_q;
  logic [33:0]        sum_w;
  logic [32:0]        dif_w;
  aisu_pkg::side_t    s4_side_q;
  logic               s4_v_q;

  always_comb begin
    sum_w   = 34'(d2_side.e_val) + 34'(d2_einv);
    dif_w   = d2_side.e_val - 33'(d2_einv);
    s4_ch_d = sum_w[33:1];
    s4_sh_d = d2_side.neg ? -$signed({2'b00, dif_w[32:1]}) : $signed({2'b00, dif_w[32:1]});
  end

  // s5: rho*sinh and m*cosh
  logic signed [65:0] s5_ps_d, s5_ps_q, s5_pc_d, s5_pc_q;
  aisu_pkg::side_t    s5_side_q;
  logic               s5_v_q;

  assign s5_ps_d = 66'(s4_side_q.rc) * 66'(s4_sh_q);
  assign s5_pc_d = 66'(s4_side_q.mc) * 66'($signed({1'b0, s4_ch_q}));

  // s6: drive bracket
  logic signed [65:0] bdiff_w;
  logic signed [31:0] s6_br_d, s6_br_q;
  aisu_pkg::side_t    s6_side_d, s6_side_q;
  logic               s6_v_q;

  always_comb begin
    bdiff_w   = (s5_ps_q >>> FW) - (s5_pc_q >>> FW);
    s6_br_d   = aisu_pkg::sat_data(SW'(bdiff_w));
    s6_side_d = s5_side_q;
    s6_side_d.ovf = s5_side_q.ovf || (aisu_pkg::sat_hit(SW'(bdiff_w)) && !s5_side_q.invalid);
  end

  // s7: coefficient products
  logic signed [63:0] s7_pam_q, s7_pdr_q, s7_par_q, s7_pdm_q, s7_pg_q;
  aisu_pkg::side_t    s7_side_q;
  logic               s7_v_q;

  // output stage
  logic signed [SW-1:0] rn_w, mn_w, drive_w;
  logic signed [31:0]   rn_q, mn_q;
  logic                 inv_q, ovf_q, out_v_q;

  always_comb begin
    drive_w = s7_side_q.invalid ? '0 : SW'(s7_pg_q >>> FW);
    rn_w = SW'(s7_side_q.rc) - SW'(s7_pam_q >>> FW) + SW'(s7_pdr_q >>> FW);
    mn_w = SW'(s7_side_q.mc) - SW'(s7_par_q >>> FW) + SW'(s7_pdm_q >>> FW) + drive_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      s7_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= d1_v;
      s4_v_q  <= d2_v;
      s5_v_q  <= s4_v_q;
      s6_v_q  <= s5_v_q;
      s7_v_q  <= s6_v_q;
      out_v_q <= s7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (in_valid_i) begin
        s1_side_q <= s1_side_d;
        s1_prod_q <= s1_prod_d;
      end
      if (s1_v_q) begin
        s2_side_q <= s2_side_d;
        s2_mag_q  <= s2_mag_d;
      end
      if (d1_v) begin
        s3_side_q <= s3_side_d;
        s3_arg_q  <= s3_arg_d;
      end
      if (d2_v) begin
        s4_side_q <= d2_side;
        s4_ch_q   <= s4_ch_d;
        s4_sh_q   <= s4_sh_d;
      end
      if (s4_v_q) begin
        s5_side_q <= s4_side_q;
        s5_ps_q   <= s5_ps_d;
        s5_pc_q   <= s5_pc_d;
      end
      if (s5_v_q) begin
        s6_side_q <= s6_side_d;
        s6_br_q   <= s6_br_d;
      end
      if (s6_v_q) begin
        s7_side_q <= s6_side_q;
        s7_pam_q  <= 64'(advect_q) * 64'(s6_side_q.grad_m);
        s7_pdr_q  <= 64'(diffuse_q) * 64'(s6_side_q.lap_r);
        s7_par_q  <= 64'(advect_q) * 64'(s6_side_q.grad_r);
        s7_pdm_q  <= 64'(diffuse_q) * 64'(s6_side_q.lap_m);
        s7_pg_q   <= 64'(gain_q) * 64'(s6_br_q);
      end
      if (s7_v_q) begin
        rn_q  <= aisu_pkg::sat_data(rn_w);
        mn_q  <= aisu_pkg::sat_data(mn_w);
        inv_q <= s7_side_q.invalid;
        ovf_q <= s7_side_q.ovf || aisu_pkg::sat_hit(rn_w) || aisu_pkg::sat_hit(mn_w);
      end
    end
  end

  assign out_valid_o       = out_v_q;
  assign rho_next_o        = rn_q;
  assign mag_next_o        = mn_q;
  assign density_invalid_o = inv_q;
  assign overflowed_o      = ovf_q;

endmodule

FILE: tb/active_ising_stencil_update_unit_test.sv
// Self-checking testbench for the active Ising stencil update unit.
// Predicts each site update in fixed point; depends on aisu_pkg and the unit itself.
module active_ising_stencil_update_unit_test;

  localparam int          QF         = 20;
  localparam longint      W_MAX      = 64'sd2147483647;
  localparam longint      W_MIN      = -64'sd2147483648;
  localparam longint      B_LIMIT    = 64'sd8 << QF;
  localparam longint unsigned LOG2E  = 64'd1512775;
  localparam longint unsigned LN2    = 64'd726817;
  localparam longint unsigned UNITY  = 64'd1 << QF;
  localparam int          LIMIT_CYC  = 400000;
  localparam int          SETTLE_CYC = 60;

  typedef struct packed {
    logic signed [31:0] rl, rc, rr, ml, mc, mr;
  } site_t;

  typedef struct packed {
    logic signed [31:0] rho, mag;
    logic               inv, ovf;
  } update_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic signed [31:0] cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] rho_left_i = '0, rho_mid_i = '0, rho_right_i = '0;
  logic signed [31:0] mag_left_i = '0, mag_mid_i = '0, mag_right_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b1;
  logic signed [31:0] rho_next_o, mag_next_o;
  logic               density_invalid_o, overflowed_o;

  active_ising_stencil_update_unit i_dut (.*);

  always #5 clk_i = ~clk_i;

  longint  coef_a = 0, coef_d = 0, coef_g = 0, coef_beta = 0;
  site_t   sites_pending[$];
  update_t updates_due[$];
  int      errors = 0, updates_seen = 0, invalid_seen = 0, ovf_seen = 0, cycles = 0;
  bit      quiet = 1'b0;
  logic    in_took = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %0s: got %0h expected %0h (result %0d)", what, got, want, updates_seen);
    errors++;
  endtask

  function automatic longint clamp_w(input longint x, inout bit ovf);
    if (x > W_MAX) begin
      ovf = 1'b1;
      return W_MAX;
    end
    if (x < W_MIN) begin
      ovf = 1'b1;
      return W_MIN;
    end
    return x;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> QF;
  endfunction

  function automatic longint unsigned exp_q(input longint unsigned a);
    longint unsigned t, f, r, p;
    int k;
    t = (a * LOG2E) >> QF;
    k = int'(t >> QF);
    f = t & (UNITY - 1);
    r = (f * LN2) >> QF;
    p = UNITY;
    for (int i = 7; i >= 1; i--) p = UNITY + ((p * r) >> QF) / i;
    return p << (k & 15);
  endfunction

  function automatic update_t site_update(input site_t s);
    longint rl, rc, rr, ml, mc, mr, gm, gr, lr, lm, drive, b, sh, ch, br, rn, mn;
    longint unsigned e, einv;
    bit ovf, inv, neg;
    update_t u;
    rl = s.rl; rc = s.rc; rr = s.rr; ml = s.ml; mc = s.mc; mr = s.mr;
    ovf = 1'b0; inv = 1'b0; drive = 0;
    gm = clamp_w(mr - ml, ovf);
    gr = clamp_w(rr - rl, ovf);
    lr = clamp_w(rl + rr - 2 * rc, ovf);
    lm = clamp_w(ml + mr - 2 * mc, ovf);
    if (rc <= 0) begin
      inv = 1'b1;
    end else begin
      b = (coef_beta * mc) / rc;
      if (b > B_LIMIT) begin
        b = B_LIMIT; ovf = 1'b1;
      end
      if (b < -B_LIMIT) begin
        b = -B_LIMIT; ovf = 1'b1;
      end
      neg = b < 0;
      e = exp_q(neg ? -b : b);
      einv = (64'd1 << (2 * QF)) / e;
      ch = longint'((e + einv) >> 1);
      sh = longint'((e - einv) >> 1);
      if (neg) sh = -sh;
      br = clamp_w(qmul(rc, sh) - qmul(mc, ch), ovf);
      drive = qmul(coef_g, br);
    end
    rn = clamp_w(rc - qmul(coef_a, gm) + qmul(coef_d, lr), ovf);
    mn = clamp_w(mc - qmul(coef_a, gr) + qmul(coef_d, lm) + drive, ovf);
    u.rho = rn[31:0]; u.mag = mn[31:0]; u.inv = inv; u.ovf = ovf;
    return u;
  endfunction

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed($urandom_range(0, 1 << 23)) - (1 << 22);
      2: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
      3: return $urandom_range(1, 1 << 24);
      4: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
      default: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    endcase
  endfunction

  function automatic site_t rand_site();
    site_t s;
    s = {rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q()};
    if ($urandom_range(0, 2) != 0) s.rc = $urandom_range(1 << 16, 1 << 23);
    return s;
  endfunction

  task automatic write_reg(input aisu_pkg::cfg_reg_e idx, input logic signed [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      aisu_pkg::REG_ADVECT:  coef_a    = val;
      aisu_pkg::REG_DIFFUSE: coef_d    = val;
      aisu_pkg::REG_GAIN:    coef_g    = val;
      default:               coef_beta = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_coeffs(input logic signed [31:0] a, d, g, beta);
    write_reg(aisu_pkg::REG_ADVECT, a);
    write_reg(aisu_pkg::REG_DIFFUSE, d);
    write_reg(aisu_pkg::REG_GAIN, g);
    write_reg(aisu_pkg::REG_BETA, beta);
  endtask

  task automatic drain();
    wait (sites_pending.size() == 0 && !in_valid_i && updates_due.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // sender: holds a request until taken, random gaps between requests
  always @(negedge clk_i) begin
    int gap;
    if (!in_valid_i || in_took) begin
      if (gap > 0) begin
        gap--;
        in_valid_i <= 1'b0;
      end else if (sites_pending.size() != 0) begin
        site_t s;
        s = sites_pending.pop_front();
        {rho_left_i, rho_mid_i, rho_right_i, mag_left_i, mag_mid_i, mag_right_i} <= s;
        in_valid_i <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 13);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back the pipeline up
  always @(negedge clk_i) begin
    int stall, hold;
    bit held;
    if (hold > 0) begin
      hold--;
      out_ready_i <= 1'b0;
    end else if (!held && updates_seen >= 120) begin
      held = 1'b1;
      hold = 300;
      out_ready_i <= 1'b0;
    end else if (stall > 0) begin
      stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 13);
    end
  end

  always @(posedge clk_i) begin
    update_t want;
    in_took <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o)
      updates_due.push_back(site_update({rho_left_i, rho_mid_i, rho_right_i,
                                         mag_left_i, mag_mid_i, mag_right_i}));
    if (out_valid_o && out_ready_i) begin
      if (updates_due.size() == 0) begin
        $display("unexpected result %0d", updates_seen);
        errors++;
      end else begin
        want = updates_due.pop_front();
        if (rho_next_o !== want.rho) report("rho_next", rho_next_o, want.rho);
        if (mag_next_o !== want.mag) report("mag_next", mag_next_o, want.mag);
        if (density_invalid_o !== want.inv) report("density_invalid", density_invalid_o, want.inv);
        if (overflowed_o !== want.ovf) report("overflowed", overflowed_o, want.ovf);
        invalid_seen += want.inv;
        ovf_seen += want.ovf;
      end
      updates_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYC) begin
      $display("timeout with %0d results outstanding", updates_due.size());
      $display("active_ising_stencil_update_unit_test failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset coefficients, then directed corner sites
    sites_pending.push_back('0);
    sites_pending.push_back({6{32'sh7fffffff}});
    sites_pending.push_back({6{32'sh80000000}});
    drain();
    set_coeffs(32'sh80000, 32'sh40000, 32'sh19999, 32'sh100000);
    sites_pending.push_back({32'sh100000, 32'sh100000, 32'sh100000, 32'sh0, 32'sh0, 32'sh0});
    sites_pending.push_back({32'sh100000, 32'sh0, 32'sh100000, 32'sh10000, 32'sh50000, 32'sh0});
    sites_pending.push_back({32'sh0, -32'sh100000, 32'sh0, 32'sh0, 32'sh100000, 32'sh0});
    sites_pending.push_back({32'sh0, 32'sh1, 32'sh0, 32'sh0, 32'sh7fffffff, 32'sh0});
    sites_pending.push_back({32'sh0, 32'sh1, 32'sh0, 32'sh0, 32'sh80000000, 32'sh0});
    sites_pending.push_back({32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                             32'sh80000000, 32'sh7fffffff, 32'sh7fffffff});
    sites_pending.push_back({32'sh200000, 32'sh100000, 32'sh0, 32'sh0, -32'sh300000, 32'sh0});
    sites_pending.push_back({32'sh0, 32'sh7fffffff, 32'sh0, 32'sh7fffffff, 32'sh1, 32'sh80000000});
    drain();
    set_coeffs(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    for (int i = 0; i < 8; i++) sites_pending.push_back(rand_site());
    drain();

    // random phases, each under a fresh set of coefficients
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) set_coeffs(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      else if (ph == 3) set_coeffs(0, 0, 0, 0);
      else set_coeffs(rand_q(), rand_q(), rand_q(), rand_q());
      quiet = (ph == 5);
      for (int i = 0; i < 72; i++) sites_pending.push_back(rand_site());
      drain();
    end

    $display("%0d site updates checked, %0d with non-positive density, %0d saturated",
             updates_seen, invalid_seen, ovf_seen);
    $display("coefficient sets included zeros, both extremes and random values");
    if (errors == 0) $display("active_ising_stencil_update_unit_test passed");
    else $display("active_ising_stencil_update_unit_test failed");
    $finish;
  end

endmodule

FILE: filelist.f
sv/aisu_pkg.sv
sv/aisu_div_pipe.sv
sv/aisu_exp_pipe.sv
sv/active_ising_stencil_update_unit.sv
tb/active_ising_stencil_update_unit_test.sv
